[sv/dmkt_pkg.sv]
// ----------------------------------------------------------------------------
// dmkt_pkg
// Shared types and constants for the direct-mapped key table.
// ----------------------------------------------------------------------------
package dmkt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SlotsDefault    = 16;
  localparam int unsigned KeyBytesDefault = 8;

  // Field widths fixed by the item format
  localparam int unsigned KindW    = 2;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned OccW     = 5;

  // djb2 hash
  localparam logic [31:0] HashStart = 32'd5381;
  localparam int unsigned HashShift = 5;

  // Item kinds; the unused code behaves as an exists query
  typedef enum logic [KindW-1:0] {
    KIND_EXISTS = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_ERASE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key_bytes;
    logic [LenW-1:0]  key_len;
  } in_t;

  typedef struct packed {
    logic                status;
    logic                hit;
    logic [SlotIdxW-1:0] slot_index;
    logic                displaced;
    logic [OccW-1:0]     occupancy;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;        // clear one table entry
    logic load;       // capture an accepted transaction
    logic hash_step;  // fold one key byte into the hash
    logic mod_step;   // one stage of the slot remainder
    logic mem_rd;     // read the slot entry
    logic update;     // compare, write back, count
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic len_zero;
    logic hash_last;
    logic mod_last;
    logic out_free;
  } status_t;

endpackage

[sv/dmkt_ctrl.sv]
// ----------------------------------------------------------------------------
// dmkt_ctrl
// Sequencer: clearing pass, hash, remainder, slot read and update, result.
// ----------------------------------------------------------------------------
module dmkt_ctrl #(
  parameter int unsigned SLOTS = dmkt_pkg::SlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dmkt_pkg::status_t status_i,
  output dmkt_pkg::cmd_t    cmd_o
);
  import dmkt_pkg::*;

  localparam bit SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);

  localparam logic [2:0] StClear  = 3'd0;
  localparam logic [2:0] StIdle   = 3'd1;
  localparam logic [2:0] StHash   = 3'd2;
  localparam logic [2:0] StMod    = 3'd3;
  localparam logic [2:0] StRead   = 3'd4;
  localparam logic [2:0] StUpdate = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.len_zero ? StDone : StHash;
        end
      end
      StHash: begin
        cmd_o.hash_step = 1'b1;
        if (status_i.hash_last) state_d = SlotsPow2 ? StRead : StMod;
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) state_d = StRead;
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StDone;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/dmkt_dp.sv]
// ----------------------------------------------------------------------------
// dmkt_dp
// Datapath: key capture, byte-serial djb2, reciprocal remainder, slot memory,
// occupancy counter and output register.
// ----------------------------------------------------------------------------
module dmkt_dp #(
  parameter int unsigned SLOTS     = dmkt_pkg::SlotsDefault,
  parameter int unsigned KEY_BYTES = dmkt_pkg::KeyBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmkt_pkg::in_t     in_data_i,
  input  dmkt_pkg::cmd_t    cmd_i,
  output dmkt_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dmkt_pkg::out_t    out_data_o
);
  import dmkt_pkg::*;

  localparam bit          SlotsPow2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int unsigned IdxW      = $clog2(SLOTS);
  localparam int unsigned CntW      = $clog2(SLOTS + 1);
  localparam int unsigned KbW       = KEY_BYTES * 8;
  localparam int unsigned ByteW     = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned EntW      = 1 + LenW + KbW;
  localparam logic [31:0]       SlotsK   = 32'(SLOTS);
  localparam logic [31:0]       RecipM   = 32'(64'h1_0000_0000 / 64'(SLOTS));
  localparam logic [IdxW-1:0]   ClrLast  = IdxW'(SLOTS - 1);
  localparam logic [LenW-1:0]   LenMax   = LenW'(KEY_BYTES);
  localparam logic [CntW-1:0]   CntOne   = CntW'(1);

  // Remainder stages
  localparam logic [1:0] ModMul = 2'd0;
  localparam logic [1:0] ModSub = 2'd1;
  localparam logic [1:0] ModFix = 2'd2;

  // Captured transaction
  logic [KEY_BYTES-1:0][7:0] key_q;
  logic [LenW-1:0]           len_q;
  logic [KindW-1:0]          kind_q;
  logic                      rej_q;

  // Hash and remainder
  logic [31:0]      hash_q;
  logic [ByteW-1:0] byte_cnt_q;
  logic [63:0]      prod_c;
  logic [31:0]      quot_q;
  logic [31:0]      diff_q;
  logic [1:0]       mod_cnt_q;
  logic [IdxW-1:0]  rem_q;
  logic [IdxW-1:0]  idx;

  // Slot memory: {valid, length, key}
  logic [EntW-1:0] mem [SLOTS];
  logic [EntW-1:0] rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;

  // Bookkeeping
  logic [IdxW-1:0] clr_cnt_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            hit_q, disp_q;
  logic            out_valid_q;
  out_t            out_q;

  logic [LenW-1:0]           len_sat;
  logic [KEY_BYTES-1:0][7:0] key_in;
  logic                      rd_valid;
  logic [LenW-1:0]           rd_len;
  logic [KbW-1:0]            rd_key;
  logic                      hit_c;
  logic                      is_ins, is_era;

  // Saturate length and drop bytes beyond it
  always_comb begin
    len_sat = (in_data_i.key_len > LenMax) ? LenMax : in_data_i.key_len;
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_in[b] = (LenW'(b) < len_sat) ? in_data_i.key_bytes[8*b +: 8] : 8'd0;
    end
  end

  // Quotient estimate by reciprocal; it is low by at most one
  assign prod_c = {32'd0, hash_q} * {32'd0, RecipM};
  assign idx    = SlotsPow2 ? hash_q[IdxW-1:0] : rem_q;

  // Slot compare
  assign rd_valid = rd_q[EntW-1];
  assign rd_len   = rd_q[KbW +: LenW];
  assign rd_key   = rd_q[KbW-1:0];
  assign hit_c    = rd_valid && (rd_len == len_q) && (rd_key == key_q);
  assign is_ins   = (kind_q == KIND_INSERT);
  assign is_era   = (kind_q == KIND_ERASE);

  // Write port and occupancy update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = {1'b1, len_q, key_q};
    cnt_d     = cnt_q;
    if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (cmd_i.update && is_ins && !hit_c) begin
      mem_we = 1'b1;
      if (!rd_valid) cnt_d = cnt_q + CntOne;
    end else if (cmd_i.update && is_era && hit_c) begin
      mem_we    = 1'b1;
      mem_wdata = {1'b0, len_q, key_q};
      if (cnt_q != '0) cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.mem_rd) rd_q <= mem[idx];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q      <= key_in;
      len_q      <= len_sat;
      kind_q     <= in_data_i.kind;
      rej_q      <= (in_data_i.key_len == '0);
      hash_q     <= HashStart;
      byte_cnt_q <= '0;
      rem_q      <= '0;
      mod_cnt_q  <= ModMul;
    end
    if (cmd_i.hash_step) begin
      hash_q     <= (hash_q << HashShift) + hash_q + 32'(key_q[byte_cnt_q]);
      byte_cnt_q <= byte_cnt_q + ByteW'(1);
    end
    // Remainder: estimate, subtract, one corrective subtract
    if (cmd_i.mod_step) begin
      case (mod_cnt_q)
        ModMul:  quot_q <= prod_c[63:32];
        ModSub:  diff_q <= hash_q - quot_q * SlotsK;
        default: rem_q  <= (diff_q >= SlotsK) ? IdxW'(diff_q - SlotsK) : IdxW'(diff_q);
      endcase
      mod_cnt_q <= mod_cnt_q + 2'd1;
    end
    if (cmd_i.update) begin
      hit_q  <= hit_c;
      disp_q <= is_ins && !hit_c && rd_valid;
    end
    if (cmd_i.out_load) begin
      out_q.status     <= rej_q;
      out_q.hit        <= !rej_q && hit_q;
      out_q.slot_index <= rej_q ? '0 : SlotIdxW'(idx);
      out_q.displaced  <= !rej_q && disp_q;
      out_q.occupancy  <= OccW'(cnt_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + IdxW'(1);
      cnt_q <= cnt_d;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Status back to the controller
  assign status_o.clr_last  = (clr_cnt_q == ClrLast);
  assign status_o.len_zero  = (in_data_i.key_len == '0);
  assign status_o.hash_last = (LenW'(byte_cnt_q) == (len_q - LenW'(1)));
  assign status_o.mod_last  = (mod_cnt_q == ModFix);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Occupancy never exceeds the table size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(SLOTS))
    else $error("occupancy above table size");

  // One update moves the count by at most one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CntOne) ||
                     (cnt_q == $past(cnt_q) - CntOne))
    else $error("occupancy moved by more than one");

  // A result never overwrites one that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overrun");

  // A hit never displaces
  a_hit_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> !(hit_q && disp_q))
    else $error("hit and displaced together");

  // Memory is not accessed during the clearing pass except by the clear
  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |-> !(cmd_i.load || cmd_i.update || cmd_i.mem_rd))
    else $error("access during clearing pass");

endmodule

[sv/direct_mapped_key_table_top.sv]
// Flow: an accepted key of L bytes is hashed one byte at a time; when SLOTS is
//   not a power of two, the remainder unit then estimates, subtracts and corrects.
// The slot is then read and updated, and the result moves to the output register.
//   A new transaction is accepted only once the previous result has been loaded.
// Zero-length keys: no hash and no slot access; the result has status set, table untouched.
// Reset: a clearing pass empties every slot with in_ready_o low; occupancy is zero.
// ----------------------------------------------------------------------------
// direct_mapped_key_table_top
// Direct-mapped key table with djb2 slot selection: exists, insert, erase.
// ----------------------------------------------------------------------------
module direct_mapped_key_table_top #(
  parameter int unsigned SLOTS     = dmkt_pkg::SlotsDefault,
  parameter int unsigned KEY_BYTES = dmkt_pkg::KeyBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dmkt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dmkt_pkg::out_t out_data_o
);
  import dmkt_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  dmkt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  dmkt_dp #(
    .SLOTS     (SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
